[hdl/fdr_pkg.sv]
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared widths, register codes and stage types for the Fresnel dielectric
// reflectance pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;

  // port widths
  localparam int CosW    = 16;
  localparam int EtaW    = 16;
  localparam int ReflW   = 17;
  localparam int CfgIdxW = 8;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ETA_INCIDENT    = 8'd0,
    CFG_ETA_TRANSMITTED = 8'd1
  } cfg_reg_e;

  // reset values, Q4.12
  localparam logic [EtaW-1:0] EtaIncRst = 16'd4096;
  localparam logic [EtaW-1:0] EtaTrnRst = 16'd6144;

  // cosine magnitude, Q.14, at most 1.0
  localparam int MagW = 15;
  localparam logic signed [CosW-1:0] CosMax = 16'sd16384;
  localparam logic signed [CosW-1:0] CosMin = -16'sd16384;

  // intermediate widths
  localparam int SqW    = 29;  // c*c and sin^2, Q.28
  localparam int Eta2W  = 32;  // eta^2
  localparam int LhsW   = 61;  // eta_i^2 * sin^2
  localparam int RemW   = 60;  // radicand, Q.52
  localparam int RootW  = 30;  // root bits, Q.26
  localparam int ApW    = 47;  // parallel terms, Q.38
  localparam int AqW    = 31;  // perpendicular terms, Q.26
  localparam int DivW   = 48;  // divider operands
  localparam int FracW  = 30;  // quotient fraction bits
  localparam int RatW   = 31;  // ratio with 1.0 = 2^30
  localparam int RSqW   = 62;  // ratio squared
  localparam int SumW   = 63;  // sum of squares with rounding

  localparam logic [RatW-1:0]  RatOne   = 31'h4000_0000;
  localparam logic [SqW-1:0]   SqOne    = 29'h1000_0000;
  localparam logic [SumW-1:0]  RoundAdd = 63'd1 << 44;
  localparam int               OutShift = 45;
  localparam logic [ReflW-1:0] ReflOne  = 17'h1_0000;

  // sideband carried through the root pipeline
  typedef struct packed {
    logic [EtaW-1:0] ei;
    logic [ApW-1:0]  ap;
    logic [AqW-1:0]  aq;
    logic            tir;
  } sq_side_t;

  // one divider lane
  typedef struct packed {
    logic [DivW-1:0]  rem;
    logic [DivW-1:0]  den;
    logic [FracW-1:0] q;
    logic             one;
  } div_lane_t;

  // ratio magnitudes leaving the divider
  typedef struct packed {
    logic [RatW-1:0] rp;
    logic [RatW-1:0] rq;
    logic            tir;
  } ratio_t;

endpackage

[hdl/fresnel_dielectric_reflectance_top.sv]
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_top
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined.
// ----------------------------------------------------------------------------
// One cosine word enters per clock and one reflectance word leaves per clock
// while the output is taken. The path is four front stages (clamp, squares,
// products, TIR test), 30 square-root stages (one root bit each), two ratio
// setup stages, 30 divider stages (one quotient bit each), squaring, then the
// output register. The whole pipeline advances together; it holds when the
// output word is not taken. Index registers are written through the config
// port, which is always ready; write them only while the pipeline is empty.
module fresnel_dielectric_reflectance_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [fdr_pkg::CosW-1:0]  cos_incident_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fdr_pkg::ReflW-1:0]        reflectance_o,
  output logic                             total_internal_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fdr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fdr_pkg::EtaW-1:0]         cfg_data_i
);
  import fdr_pkg::*;

  logic en;

  // config registers
  logic [EtaW-1:0] eta_inc_q, eta_trn_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_inc_q <= EtaIncRst;
      eta_trn_q <= EtaTrnRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ETA_INCIDENT:    eta_inc_q <= cfg_data_i;
        CFG_ETA_TRANSMITTED: eta_trn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline body
  logic              f_valid;
  logic [RemW-1:0]   f_d;
  sq_side_t          f_side;
  logic              s_valid;
  logic [RootW-1:0]  s_t;
  sq_side_t          s_side;
  logic              r_valid;
  ratio_t            r_ratio;

  fdr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .cos_i     (cos_incident_i),
    .eta_inc_i (eta_inc_q),
    .eta_trn_i (eta_trn_q),
    .valid_o   (f_valid),
    .d_o       (f_d),
    .side_o    (f_side)
  );

  fdr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .d_i     (f_d),
    .side_i  (f_side),
    .valid_o (s_valid),
    .t_o     (s_t),
    .side_o  (s_side)
  );

  fdr_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .t_i     (s_t),
    .side_i  (s_side),
    .valid_o (r_valid),
    .ratio_o (r_ratio)
  );

  // squares of the ratios
  logic            vsq_q;
  logic [RSqW-1:0] sqp_q, sqq_q;
  logic            tirsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsq_q <= 1'b0;
    end else if (en) begin
      vsq_q <= r_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqp_q   <= RSqW'(r_ratio.rp) * RSqW'(r_ratio.rp);
      sqq_q   <= RSqW'(r_ratio.rq) * RSqW'(r_ratio.rq);
      tirsq_q <= r_ratio.tir;
    end
  end

  // average, round, saturate; output register
  logic [SumW-1:0]           sum;
  logic [SumW-OutShift-1:0]  scaled;
  logic                      out_valid_q;
  logic [ReflW-1:0]          refl_q;
  logic                      tir_q;

  assign sum    = SumW'(sqp_q) + SumW'(sqq_q) + RoundAdd;
  assign scaled = sum[SumW-1:OutShift];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vsq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tirsq_q || scaled > (SumW-OutShift)'(ReflOne)) begin
        refl_q <= ReflOne;
      end else begin
        refl_q <= scaled[ReflW-1:0];
      end
      tir_q <= tirsq_q;
    end
  end

  // pipeline moves when the output word is free or being taken
  assign en               = !out_valid_q || out_ready_i;
  assign in_ready_o       = en;
  assign out_valid_o      = out_valid_q;
  assign reflectance_o    = refl_q;
  assign total_internal_o = tir_q;

`ifndef NO_ASSERTIONS
  a_tir_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_internal_o |-> reflectance_o == ReflOne)
    else $error("TIR word without full reflectance");

  a_refl_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reflectance_o <= ReflOne)
    else $error("reflectance above one");

  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vsq_q) && $stable(r_valid))
    else $error("pipeline moved during stall");
`endif

endmodule

[hdl/fdr_front.sv]
// ----------------------------------------------------------------------------
// fdr_front
// Clamp and side select, squares, products and the exact TIR test. Four
// register stages ending in the radicand of the transmitted cosine.
// ----------------------------------------------------------------------------
module fdr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [fdr_pkg::CosW-1:0] cos_i,
  input  logic [fdr_pkg::EtaW-1:0]     eta_inc_i,
  input  logic [fdr_pkg::EtaW-1:0]     eta_trn_i,
  output logic                         valid_o,
  output logic [fdr_pkg::RemW-1:0]     d_o,
  output fdr_pkg::sq_side_t            side_o
);
  import fdr_pkg::*;

  logic signed [CosW-1:0] clamp;
  logic signed [CosW-1:0] neg;
  logic                   enter;

  // stage A: clamp, magnitude, index swap
  logic            va_q;
  logic [MagW-1:0] ca_q;
  logic [EtaW-1:0] eia_q, eta_q;

  always_comb begin
    if (cos_i > CosMax) begin
      clamp = CosMax;
    end else if (cos_i < CosMin) begin
      clamp = CosMin;
    end else begin
      clamp = cos_i;
    end
    enter = clamp > 16'sd0;
    neg   = -clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q  <= enter ? clamp[MagW-1:0] : neg[MagW-1:0];
      eia_q <= enter ? eta_inc_i : eta_trn_i;
      eta_q <= enter ? eta_trn_i : eta_inc_i;
    end
  end

  // stage B: squares
  logic             vb_q;
  logic [MagW-1:0]  cb_q;
  logic [EtaW-1:0]  eib_q;
  logic [SqW-1:0]   c2b_q;
  logic [Eta2W-1:0] ei2b_q, et2b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cb_q   <= ca_q;
      eib_q  <= eia_q;
      c2b_q  <= SqW'(ca_q) * SqW'(ca_q);
      ei2b_q <= Eta2W'(eia_q) * Eta2W'(eia_q);
      et2b_q <= Eta2W'(eta_q) * Eta2W'(eta_q);
    end
  end

  // stage C: sin^2 products and ratio terms
  logic             vc_q;
  logic [EtaW-1:0]  eic_q;
  logic [LhsW-1:0]  lhsc_q;
  logic [RemW-1:0]  rhsc_q;
  logic [ApW-1:0]   apc_q;
  logic [AqW-1:0]   aqc_q;
  logic [SqW-1:0]   s2;

  assign s2 = SqOne - c2b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eic_q  <= eib_q;
      lhsc_q <= LhsW'(ei2b_q) * LhsW'(s2);
      rhsc_q <= {et2b_q, 28'd0};
      apc_q  <= ApW'(et2b_q) * ApW'(cb_q);
      aqc_q  <= AqW'(eib_q) * AqW'(cb_q);
    end
  end

  // stage D: TIR compare and radicand
  logic        vd_q;
  logic [RemW-1:0] dd_q;
  sq_side_t    sided_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q        <= rhsc_q - lhsc_q[RemW-1:0];
      sided_q.ei  <= eic_q;
      sided_q.ap  <= apc_q;
      sided_q.aq  <= aqc_q;
      sided_q.tir <= lhsc_q >= {1'b0, rhsc_q};
    end
  end

  assign valid_o = vd_q;
  assign d_o     = dd_q;
  assign side_o  = sided_q;

endmodule

[hdl/fdr_sqrt.sv]
// ----------------------------------------------------------------------------
// fdr_sqrt
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module fdr_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [fdr_pkg::RemW-1:0]  d_i,
  input  fdr_pkg::sq_side_t         side_i,
  output logic                      valid_o,
  output logic [fdr_pkg::RootW-1:0] t_o,
  output fdr_pkg::sq_side_t         side_o
);
  import fdr_pkg::*;

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  sq_side_t         side_q [RootW];
  logic [RootW-1:0] v_q;

  logic [RemW-1:0]  rem_in  [RootW];
  logic [RootW-1:0] root_in [RootW];
  sq_side_t         side_in [RootW];
  logic [RootW-1:0] v_in;

  assign rem_in[0]  = d_i;
  assign root_in[0] = '0;
  assign side_in[0] = side_i;
  assign v_in[0]    = valid_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int B = RootW - 1 - k;
    logic [RemW-1:0] trial;
    logic            ge;

    if (k > 0) begin : g_link
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign side_in[k] = side_q[k-1];
      assign v_in[k]    = v_q[k-1];
    end

    // trial = (2*root + 2^B) * 2^B; low root bits are still zero
    assign trial = (RemW'(root_in[k]) << (B + 1)) | (RemW'(1) << (2 * B));
    assign ge    = rem_in[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_in[k] - trial : rem_in[k];
        root_q[k] <= root_in[k] | (RootW'(ge) << B);
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign t_o     = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

[hdl/fdr_ratio.sv]
// ----------------------------------------------------------------------------
// fdr_ratio
// Parallel and perpendicular amplitude ratio magnitudes: term products,
// sums and differences, then two restoring dividers, one quotient bit a stage.
// ----------------------------------------------------------------------------
module fdr_ratio (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [fdr_pkg::RootW-1:0] t_i,
  input  fdr_pkg::sq_side_t         side_i,
  output logic                      valid_o,
  output fdr_pkg::ratio_t           ratio_o
);
  import fdr_pkg::*;

  // stage P: ei * t
  logic           vp_q;
  logic [ApW-1:0] app_q, bpp_q;
  logic [AqW-1:0] aqp_q;
  logic [RootW-1:0] tp_q;
  logic           tirp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      app_q  <= side_i.ap;
      bpp_q  <= ApW'(side_i.ei) * ApW'(t_i);
      aqp_q  <= side_i.aq;
      tp_q   <= t_i;
      tirp_q <= side_i.tir;
    end
  end

  // stage Q: |a - b| and a + b for both lanes
  logic            vs_q;
  logic [DivW-1:0] num_q [2];
  logic [DivW-1:0] den_q [2];
  logic            tirs_q;
  logic [DivW-1:0] a_w [2];
  logic [DivW-1:0] b_w [2];

  assign a_w[0] = DivW'(app_q);
  assign b_w[0] = DivW'(bpp_q);
  assign a_w[1] = DivW'(aqp_q);
  assign b_w[1] = DivW'(tp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en_i) begin
      vs_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= (a_w[l] >= b_w[l]) ? a_w[l] - b_w[l] : b_w[l] - a_w[l];
        den_q[l] <= a_w[l] + b_w[l];
      end
      tirs_q <= tirp_q;
    end
  end

  // divider stages; a numerator at or above its denominator gives 1.0
  div_lane_t        lane_q  [FracW][2];
  div_lane_t        lane_in [FracW][2];
  logic [FracW-1:0] v_q;
  logic [FracW-1:0] tir_q;
  logic [FracW-1:0] v_in;
  logic [FracW-1:0] tir_in;

  for (genvar l = 0; l < 2; l++) begin : g_lane0
    assign lane_in[0][l].rem = num_q[l];
    assign lane_in[0][l].den = den_q[l];
    assign lane_in[0][l].q   = '0;
    assign lane_in[0][l].one = num_q[l] >= den_q[l];
  end
  assign v_in[0]   = vs_q;
  assign tir_in[0] = tirs_q;

  for (genvar k = 0; k < FracW; k++) begin : g_div
    if (k > 0) begin : g_link
      assign lane_in[k] = lane_q[k-1];
      assign v_in[k]    = v_q[k-1];
      assign tir_in[k]  = tir_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_l
      logic [DivW:0] r2;
      logic          ge;
      logic [DivW:0] diff;

      assign r2   = {lane_in[k][l].rem, 1'b0};
      assign ge   = r2 >= {1'b0, lane_in[k][l].den};
      assign diff = r2 - {1'b0, lane_in[k][l].den};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lane_q[k][l].rem <= ge ? diff[DivW-1:0] : r2[DivW-1:0];
          lane_q[k][l].den <= lane_in[k][l].den;
          lane_q[k][l].q   <= {lane_in[k][l].q[FracW-2:0], ge};
          lane_q[k][l].one <= lane_in[k][l].one;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tir_q[k] <= tir_in[k];
      end
    end
  end

  assign valid_o     = v_q[FracW-1];
  assign ratio_o.rp  = lane_q[FracW-1][0].one ? RatOne : {1'b0, lane_q[FracW-1][0].q};
  assign ratio_o.rq  = lane_q[FracW-1][1].one ? RatOne : {1'b0, lane_q[FracW-1][1].q};
  assign ratio_o.tir = tir_q[FracW-1];

endmodule
